@@ sv/scl_pkg.sv @@
// scl_pkg: shared types and constants of the sector cache lru manager
// field widths, request kinds, result codes, sequencer states
// no dependencies
package scl_pkg;

  localparam int DRIVE_W   = 4;
  localparam int SECTOR_W  = 32;
  localparam int KIND_W    = 3;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int DPRES_W   = 16;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN         = 3'd0,
    KIND_MARK_READ    = 3'd1,
    KIND_MARK_WRITTEN = 3'd2,
    KIND_FLUSH_ONE    = 3'd3,
    KIND_FLUSH_ALL    = 3'd4,
    KIND_INVALIDATE   = 3'd5
  } kind_t;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_ANSWER     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE_BACK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FETCH      = 2'd2;

  // answer status codes
  localparam logic [STATUS_W-1:0] STAT_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_HIT        = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ALLOCATED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_CACHED = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NO_DRIVE   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PRESENT = 2'd1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH_WB,
    S_DECIDE,
    S_CMD,
    S_ANS
  } state_t;

endpackage

@@ sv/scl_req_if.sv @@
// scl_req_if: request channel of the sector cache lru manager
// depends on scl_pkg for field widths
interface scl_req_if import scl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DRIVE_W-1:0]  drive;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, kind, drive, sector, input ready);
  modport sink (input valid, kind, drive, sector, output ready);
endinterface

@@ sv/scl_rsp_if.sv @@
// scl_rsp_if: result channel of the sector cache lru manager
// depends on scl_pkg for field widths
interface scl_rsp_if import scl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [DRIVE_W-1:0]  cmd_drive;
  logic [SECTOR_W-1:0] cmd_sector;
  logic                last;

  modport source (output valid, action, status, slot, cmd_drive, cmd_sector, last,
                  input ready);
  modport sink (input valid, action, status, slot, cmd_drive, cmd_sector, last,
                output ready);
endinterface

@@ sv/scl_cfg_if.sv @@
// scl_cfg_if: configuration write channel of the sector cache lru manager
// depends on scl_pkg for index and data widths
interface scl_cfg_if import scl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/sector_cache_lru_manager.sv @@
// Sequence: open, mark read, mark written and flush one scan every entry (a memory read and
// a compare per entry), then a decide step and the results, a command ahead of the answer
// where one is needed; flush all sends a write-back per dirty entry of a present drive
// during the scan, then the answer; invalidate and unknown kinds skip the scan. A result
// waits while the output register is held. One request at a time: ready is high only in idle.
// Reset: synchronous, clears valid/dirty/loaded flags, registers and output; no clearing pass.
// depends on scl_pkg, scl_req_if, scl_rsp_if, scl_cfg_if
module sector_cache_lru_manager import scl_pkg::*; #(
  parameter int ENTRIES  = 8,
  parameter int AGE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  scl_req_if.sink   in_ch,
  scl_rsp_if.source out_ch,
  scl_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  typedef struct packed {
    logic [DRIVE_W-1:0]  drive;
    logic [SECTOR_W-1:0] sector;
    logic [AGE_BITS-1:0] age;
  } word_t;

  // tag and age memory, one read and one write port
  word_t mem [ENTRIES];
  word_t rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  word_t             mem_wdata;

  // configuration registers
  logic [SECTOR_W-1:0] sector_limit_r;
  logic [DPRES_W-1:0]  drive_present_r;

  // sequencer and request registers
  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;

  // scan results
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [AGE_BITS-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]    vic_idx_r, vic_idx_nxt;
  logic                stop_r, stop_nxt;
  logic                vic_wb_r, vic_wb_nxt;
  logic [DRIVE_W-1:0]  vic_drive_r, vic_drive_nxt;
  logic [SECTOR_W-1:0] vic_sector_r, vic_sector_nxt;

  // per-entry flags
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;
  logic [ENTRIES-1:0] loaded_r, loaded_nxt;

  // pending command and answer
  logic [ACTION_W-1:0] cmd_action_r, cmd_action_nxt;
  logic [IDX_W-1:0]    cmd_slot_r, cmd_slot_nxt;
  logic [DRIVE_W-1:0]  cmd_drive_r, cmd_drive_nxt;
  logic [SECTOR_W-1:0] cmd_sector_r, cmd_sector_nxt;
  logic [STATUS_W-1:0] ans_status_r, ans_status_nxt;
  logic [IDX_W-1:0]    ans_slot_r, ans_slot_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [ACTION_W-1:0] out_action_r, out_action_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [DRIVE_W-1:0]  out_drive_r, out_drive_nxt;
  logic [SECTOR_W-1:0] out_sector_r, out_sector_nxt;
  logic                out_last_r, out_last_nxt;

  logic out_free;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.action     = out_action_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.cmd_drive  = out_drive_r;
  assign out_ch.cmd_sector = out_sector_r;
  assign out_ch.last       = out_last_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // memory access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[ptr_r];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_limit_r  <= '0;
      drive_present_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_SECTOR_LIMIT) begin
        sector_limit_r <= cfg_ch.data;
      end else if (cfg_ch.index == CFG_DRIVE_PRESENT) begin
        drive_present_r <= cfg_ch.data[DPRES_W-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      dirty_r     <= '0;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    drive_r      <= drive_nxt;
    sector_r     <= sector_nxt;
    ptr_r        <= ptr_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    best_r       <= best_nxt;
    vic_idx_r    <= vic_idx_nxt;
    stop_r       <= stop_nxt;
    vic_wb_r     <= vic_wb_nxt;
    vic_drive_r  <= vic_drive_nxt;
    vic_sector_r <= vic_sector_nxt;
    cmd_action_r <= cmd_action_nxt;
    cmd_slot_r   <= cmd_slot_nxt;
    cmd_drive_r  <= cmd_drive_nxt;
    cmd_sector_r <= cmd_sector_nxt;
    ans_status_r <= ans_status_nxt;
    ans_slot_r   <= ans_slot_nxt;
    out_action_r <= out_action_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_drive_r  <= out_drive_nxt;
    out_sector_r <= out_sector_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sequencer: next state, shared scan compare, results
  always_comb begin
    logic                ent_valid;
    logic [AGE_BITS-1:0] age_in;
    logic [AGE_BITS-1:0] age_new;
    logic                match;
    logic                take;
    logic                advance;

    state_nxt      = state_r;
    kind_nxt       = kind_r;
    drive_nxt      = drive_r;
    sector_nxt     = sector_r;
    ptr_nxt        = ptr_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    best_nxt       = best_r;
    vic_idx_nxt    = vic_idx_r;
    stop_nxt       = stop_r;
    vic_wb_nxt     = vic_wb_r;
    vic_drive_nxt  = vic_drive_r;
    vic_sector_nxt = vic_sector_r;
    valid_nxt      = valid_r;
    dirty_nxt      = dirty_r;
    loaded_nxt     = loaded_r;
    cmd_action_nxt = cmd_action_r;
    cmd_slot_nxt   = cmd_slot_r;
    cmd_drive_nxt  = cmd_drive_r;
    cmd_sector_nxt = cmd_sector_r;
    ans_status_nxt = ans_status_r;
    ans_slot_nxt   = ans_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_action_nxt = out_action_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_drive_nxt  = out_drive_r;
    out_sector_nxt = out_sector_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = rd_data_r;
    advance        = 1'b0;

    // compare and aging of the entry under the scan pointer
    ent_valid = valid_r[ptr_r];
    age_in    = ent_valid ? rd_data_r.age : AGE_MAX;
    age_new   = (ent_valid && (age_in != AGE_MAX)) ? age_in + 1'b1 : age_in;
    match     = ent_valid && (rd_data_r.drive == drive_r) && (rd_data_r.sector == sector_r);
    take      = !stop_r && (best_r <= age_new);

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt       = kind_t'(in_ch.kind);
          drive_nxt      = in_ch.drive;
          sector_nxt     = in_ch.sector;
          ptr_nxt        = '0;
          hit_nxt        = 1'b0;
          hit_idx_nxt    = '0;
          best_nxt       = '0;
          vic_idx_nxt    = '0;
          stop_nxt       = 1'b0;
          vic_wb_nxt     = 1'b0;
          ans_status_nxt = STAT_DONE;
          ans_slot_nxt   = '0;
          if (in_ch.kind <= KIND_W'(KIND_FLUSH_ALL)) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      // memory read of the entry under the pointer
      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (match && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = ptr_r;
        end
        if (kind_r == KIND_OPEN) begin
          // age the entry and track the oldest one as victim
          mem_we        = ent_valid;
          mem_wdata.age = age_new;
          if (take) begin
            best_nxt       = age_new;
            vic_idx_nxt    = ptr_r;
            vic_wb_nxt     = ent_valid && dirty_r[ptr_r];
            vic_drive_nxt  = rd_data_r.drive;
            vic_sector_nxt = rd_data_r.sector;
            stop_nxt       = (age_new == AGE_MAX);
          end
          advance = 1'b1;
        end else if (kind_r == KIND_FLUSH_ALL && ent_valid && dirty_r[ptr_r] &&
                     drive_present_r[rd_data_r.drive]) begin
          state_nxt = S_FLUSH_WB;
        end else begin
          advance = 1'b1;
        end
      end

      // write-back of one dirty entry during flush all
      S_FLUSH_WB: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_action_nxt   = ACT_WRITE_BACK;
          out_status_nxt   = STAT_DONE;
          out_slot_nxt     = SLOT_W'(ptr_r);
          out_drive_nxt    = rd_data_r.drive;
          out_sector_nxt   = rd_data_r.sector;
          out_last_nxt     = 1'b0;
          dirty_nxt[ptr_r] = 1'b0;
          advance          = 1'b1;
        end
      end

      // act on the scan result
      S_DECIDE: begin
        state_nxt = S_ANS;
        unique case (kind_r)
          KIND_OPEN: begin
            if (hit_r) begin
              mem_we         = 1'b1;
              mem_waddr      = hit_idx_r;
              mem_wdata      = {drive_r, sector_r, {AGE_BITS{1'b0}}};
              ans_status_nxt = STAT_HIT;
              ans_slot_nxt   = hit_idx_r;
            end else if (!drive_present_r[drive_r]) begin
              ans_status_nxt = STAT_NO_DRIVE;
            end else if (sector_r >= sector_limit_r) begin
              ans_status_nxt = STAT_RANGE;
            end else begin
              if (vic_wb_r && drive_present_r[vic_drive_r]) begin
                cmd_action_nxt = ACT_WRITE_BACK;
                cmd_slot_nxt   = vic_idx_r;
                cmd_drive_nxt  = vic_drive_r;
                cmd_sector_nxt = vic_sector_r;
                state_nxt      = S_CMD;
              end
              mem_we                = 1'b1;
              mem_waddr             = vic_idx_r;
              mem_wdata             = {drive_r, sector_r, {AGE_BITS{1'b0}}};
              valid_nxt[vic_idx_r]  = 1'b1;
              dirty_nxt[vic_idx_r]  = 1'b0;
              loaded_nxt[vic_idx_r] = 1'b0;
              ans_status_nxt        = STAT_ALLOCATED;
              ans_slot_nxt          = vic_idx_r;
            end
          end
          KIND_MARK_READ: begin
            ans_slot_nxt = hit_idx_r;
            if (!hit_r) begin
              ans_status_nxt = STAT_NOT_CACHED;
            end else if (!loaded_r[hit_idx_r]) begin
              loaded_nxt[hit_idx_r] = 1'b1;
              if (!drive_present_r[drive_r]) begin
                ans_status_nxt = STAT_NO_DRIVE;
              end else begin
                cmd_action_nxt = ACT_FETCH;
                cmd_slot_nxt   = hit_idx_r;
                cmd_drive_nxt  = drive_r;
                cmd_sector_nxt = sector_r;
                state_nxt      = S_CMD;
              end
            end
          end
          KIND_MARK_WRITTEN: begin
            ans_slot_nxt = hit_idx_r;
            if (!hit_r) begin
              ans_status_nxt = STAT_NOT_CACHED;
            end else begin
              dirty_nxt[hit_idx_r]  = 1'b1;
              loaded_nxt[hit_idx_r] = 1'b1;
            end
          end
          KIND_FLUSH_ONE: begin
            ans_slot_nxt = hit_idx_r;
            if (!hit_r) begin
              ans_status_nxt = STAT_NOT_CACHED;
            end else if (dirty_r[hit_idx_r]) begin
              if (drive_present_r[drive_r]) begin
                dirty_nxt[hit_idx_r] = 1'b0;
                cmd_action_nxt       = ACT_WRITE_BACK;
                cmd_slot_nxt         = hit_idx_r;
                cmd_drive_nxt        = drive_r;
                cmd_sector_nxt       = sector_r;
                state_nxt            = S_CMD;
              end else begin
                ans_status_nxt = STAT_NO_DRIVE;
              end
            end
          end
          KIND_INVALIDATE: begin
            valid_nxt  = '0;
            dirty_nxt  = '0;
            loaded_nxt = '0;
          end
          default: begin
          end
        endcase
        // slot zero stands for "no entry" on a miss
        if (!hit_r && kind_r != KIND_OPEN) begin
          ans_slot_nxt = '0;
        end
      end

      // command ahead of the answer
      S_CMD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = cmd_action_r;
          out_status_nxt = STAT_DONE;
          out_slot_nxt   = SLOT_W'(cmd_slot_r);
          out_drive_nxt  = cmd_drive_r;
          out_sector_nxt = cmd_sector_r;
          out_last_nxt   = 1'b0;
          state_nxt      = S_ANS;
        end
      end

      // final answer of the request
      S_ANS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_ANSWER;
          out_status_nxt = ans_status_r;
          out_slot_nxt   = SLOT_W'(ans_slot_r);
          out_drive_nxt  = '0;
          out_sector_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step the scan pointer or leave the scan
    if (advance) begin
      if (ptr_r == LAST_IDX) begin
        state_nxt = (kind_r == KIND_FLUSH_ALL) ? S_ANS : S_DECIDE;
      end else begin
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_READ;
      end
    end
  end

endmodule
